FILE: rtl/core/fcsg_pkg.sv
// Filled circle span generator: shared widths, register indexes and types.
// No dependencies; every other file of the block imports this package.
package fcsg_pkg;

	// Field widths fixed by the command and span formats
	localparam int RAD_W     = 6;
	localparam int SQ_W      = 11;   // holds squares up to 32*32
	localparam int LEN_W     = 7;
	localparam int SCR_W     = 13;
	localparam int COLOR_W   = 32;
	localparam int CFG_IDX_W = 2;

	// Defaults for the top-level parameters
	localparam int DEF_MAX_RADIUS = 32;
	localparam int DEF_COORD_BITS = 12;

	// Register map
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

	localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
	localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

	// Screen size as seen by the sequencer
	typedef struct packed {
		logic [SCR_W-1:0] width;
		logic [SCR_W-1:0] height;
	} screen_t;

	// Result of the shared compare-and-step unit
	typedef struct packed {
		logic            over;     // r^2 + h^2 > R^2 and h can still shrink
		logic [SQ_W-1:0] hh_next;  // (h-1)^2
	} cmp_res_t;

endpackage

FILE: rtl/core/fcsg_if.sv
// Filled circle span generator: valid/ready channel interfaces.
// Depends on fcsg_pkg for field widths.

// Circle command channel
interface fcsg_cmd_if #(parameter int COORD_BITS = fcsg_pkg::DEF_COORD_BITS);
	import fcsg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] center_x;
	logic [COORD_BITS-1:0] center_y;
	logic [RAD_W-1:0]      circle_radius;
	logic [COLOR_W-1:0]    fill_color;

	modport source (output valid, center_x, center_y, circle_radius, fill_color,
		input ready);
	modport sink (input valid, center_x, center_y, circle_radius, fill_color,
		output ready);
endinterface

// Span result channel
interface fcsg_span_if #(parameter int COORD_BITS = fcsg_pkg::DEF_COORD_BITS);
	import fcsg_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] span_row;
	logic [COORD_BITS-1:0] span_start;
	logic [LEN_W-1:0]      span_length;
	logic [COLOR_W-1:0]    span_color;
	logic                  last_span;

	modport source (output valid, span_row, span_start, span_length, span_color,
		last_span, input ready);
	modport sink (input valid, span_row, span_start, span_length, span_color,
		last_span, output ready);
endinterface

// Configuration write channel
interface fcsg_cfg_if;
	import fcsg_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] addr;
	logic [SCR_W-1:0]     data;

	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/filled_circle_span_generator_top.sv
// Filled circle span generator: top level.
// Depends on fcsg_pkg, fcsg_if, fcsg_cfg_regs and fcsg_seq.
//
//   channel  direction  carries
//   cmd      in         center_x, center_y, circle_radius, fill_color
//   span     out        span_row, span_start, span_length, span_color, last_span
//   cfg      in         addr (0 screen_width, 1 screen_height), data
//
// A command passes an accept state and a check state; a rejected command ends
// there. An accepted radius R adds the middle span and, per row offset 1..R-1,
// a top and a bottom span after the compare steps that shrink the half-width.
// Reset sets the screen to 640 x 480 and returns the sequencer to idle.
// A stalled span holds in the output register and the sequencer waits on it.
module filled_circle_span_generator_top #(
	parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
	parameter int COORD_BITS = fcsg_pkg::DEF_COORD_BITS
) (
	input logic         clk,
	input logic         arst_n,
	fcsg_cmd_if.sink    cmd,
	fcsg_span_if.source span,
	fcsg_cfg_if.sink    cfg
);
	import fcsg_pkg::*;

	screen_t screen;

	fcsg_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.screen (screen)
	);

	fcsg_seq #(
		.MAX_RADIUS (MAX_RADIUS),
		.COORD_BITS (COORD_BITS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.screen (screen),
		.cmd    (cmd),
		.span   (span)
	);

	// Block is busy right after taking a request
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("command taken while previous one in progress");

	// Spans always have odd length
	a_len_odd: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid |-> span.span_length[0])
		else $error("span length is even");

	// Span never wider than the largest circle
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		span.valid |-> (span.span_length <= LEN_W'(2 * MAX_RADIUS + 1)))
		else $error("span longer than largest diameter");

endmodule

FILE: rtl/core/fcsg_cfg_regs.sv
// Filled circle span generator: screen size registers.
// Depends on fcsg_pkg and fcsg_cfg_if.
module fcsg_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	fcsg_cfg_if.sink          cfg,
	output fcsg_pkg::screen_t screen
);
	import fcsg_pkg::*;

	logic [SCR_W-1:0] width_q;
	logic [SCR_W-1:0] height_q;

	// Writes are always taken; unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SCREEN_WIDTH_RST;
			height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_SCREEN_WIDTH:  width_q  <= cfg.data;
				REG_SCREEN_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign screen.width  = width_q;
	assign screen.height = height_q;

endmodule

FILE: rtl/core/fcsg_cmp_unit.sv
// Filled circle span generator: shared compare-and-step unit for the
// half-width search. Depends on fcsg_pkg.
module fcsg_cmp_unit (
	input  logic [fcsg_pkg::SQ_W-1:0]  rr,
	input  logic [fcsg_pkg::SQ_W-1:0]  hh,
	input  logic [fcsg_pkg::SQ_W-1:0]  r2,
	input  logic [fcsg_pkg::RAD_W-1:0] hw,
	output fcsg_pkg::cmp_res_t         res
);
	import fcsg_pkg::*;

	logic [SQ_W:0] sum;

	// r^2 + h^2 against R^2
	assign sum     = {1'b0, rr} + {1'b0, hh};
	assign res.over = (hw != '0) && (sum > {1'b0, r2});

	// (h-1)^2 = h^2 - 2h + 1
	assign res.hh_next = hh - SQ_W'({hw, 1'b0}) + SQ_W'(1);

endmodule

FILE: rtl/core/fcsg_seq.sv
// Filled circle span generator: command check, span sequencer and output
// register. Depends on fcsg_pkg, fcsg_if and fcsg_cmp_unit.
module fcsg_seq #(
	parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
	parameter int COORD_BITS = fcsg_pkg::DEF_COORD_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fcsg_pkg::screen_t screen,
	fcsg_cmd_if.sink          cmd,
	fcsg_span_if.source       span
);
	import fcsg_pkg::*;

	localparam int CW    = COORD_BITS + 1;
	localparam int CMP_W = (CW > SCR_W) ? CW : SCR_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_MID   = 3'd2;
	localparam logic [2:0] ST_TEST  = 3'd3;
	localparam logic [2:0] ST_TOP   = 3'd4;
	localparam logic [2:0] ST_BOT   = 3'd5;

	logic [2:0]            state_q;
	logic                  out_valid_q;

	// Command registers
	logic [COORD_BITS-1:0] cx_q;
	logic [COORD_BITS-1:0] cy_q;
	logic [RAD_W-1:0]      rad_q;
	logic [COLOR_W-1:0]    color_q;

	// Search state: row offset, half-width and their squares
	logic [RAD_W-1:0]      r_q;
	logic [RAD_W-1:0]      hw_q;
	logic [SQ_W-1:0]       rr_q;
	logic [SQ_W-1:0]       hh_q;
	logic [SQ_W-1:0]       r2_q;

	// Output register
	logic [COORD_BITS-1:0] row_q;
	logic [COORD_BITS-1:0] start_q;
	logic [LEN_W-1:0]      len_q;
	logic [COLOR_W-1:0]    span_color_q;
	logic                  last_q;

	logic [2*RAD_W-1:0]    rad_sq;
	logic [CW-1:0]         sum_x;
	logic [CW-1:0]         sum_y;
	logic                  reject;
	logic                  slot_free;
	logic                  load_mid;
	logic                  load_top;
	logic                  load_bot;
	logic                  bot_last;
	cmp_res_t              cmp;

	fcsg_cmp_unit u_cmp (
		.rr  (rr_q),
		.hh  (hh_q),
		.r2  (r2_q),
		.hw  (hw_q),
		.res (cmp)
	);

	// Radius and screen bounds check
	assign rad_sq = (2*RAD_W)'(rad_q) * (2*RAD_W)'(rad_q);
	assign sum_x  = CW'(cx_q) + CW'(rad_q);
	assign sum_y  = CW'(cy_q) + CW'(rad_q);

	always_comb begin
		reject = (rad_q == '0) || (rad_q > RAD_W'(MAX_RADIUS)) ||
			(CW'(cx_q) < CW'(rad_q)) || (CMP_W'(sum_x) >= CMP_W'(screen.width)) ||
			sum_x[COORD_BITS] ||
			(CW'(cy_q) < CW'(rad_q)) || (CMP_W'(sum_y) >= CMP_W'(screen.height)) ||
			sum_y[COORD_BITS];
	end

	assign slot_free = !out_valid_q || span.ready;
	assign load_mid  = (state_q == ST_MID) && slot_free;
	assign load_top  = (state_q == ST_TOP) && slot_free;
	assign load_bot  = (state_q == ST_BOT) && slot_free;
	assign bot_last  = (r_q + RAD_W'(1)) == rad_q;

	assign cmd.ready = (state_q == ST_IDLE);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_mid || load_top || load_bot) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= reject ? ST_IDLE : ST_MID;
				end
				ST_MID: begin
					if (slot_free) state_q <= (rad_q == RAD_W'(1)) ? ST_IDLE : ST_TEST;
				end
				ST_TEST: begin
					if (!cmp.over) state_q <= ST_TOP;
				end
				ST_TOP: begin
					if (slot_free) state_q <= ST_BOT;
				end
				ST_BOT: begin
					if (slot_free) state_q <= bot_last ? ST_IDLE : ST_TEST;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: command capture, search steps and span payload
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cx_q    <= cmd.center_x;
			cy_q    <= cmd.center_y;
			rad_q   <= cmd.circle_radius;
			color_q <= cmd.fill_color;
		end
		if (state_q == ST_CHECK) begin
			r2_q <= rad_sq[SQ_W-1:0];
			hh_q <= rad_sq[SQ_W-1:0];
			hw_q <= rad_q;
		end
		if (load_mid) begin
			r_q          <= RAD_W'(1);
			rr_q         <= SQ_W'(1);
			row_q        <= cy_q;
			start_q      <= cx_q - COORD_BITS'(rad_q);
			len_q        <= {rad_q, 1'b1};
			span_color_q <= color_q;
			last_q       <= (rad_q == RAD_W'(1));
		end
		// Shrink the half-width while the point lies outside the circle
		if ((state_q == ST_TEST) && cmp.over) begin
			hw_q <= hw_q - RAD_W'(1);
			hh_q <= cmp.hh_next;
		end
		if (load_top) begin
			row_q   <= cy_q - COORD_BITS'(r_q);
			start_q <= cx_q - COORD_BITS'(hw_q);
			len_q   <= {hw_q, 1'b1};
			last_q  <= 1'b0;
		end
		if (load_bot) begin
			row_q  <= cy_q + COORD_BITS'(r_q);
			last_q <= bot_last;
			// Step to the next row: (r+1)^2 = r^2 + 2r + 1
			r_q    <= r_q + RAD_W'(1);
			rr_q   <= rr_q + SQ_W'({r_q, 1'b0}) + SQ_W'(1);
		end
	end

	assign span.valid       = out_valid_q;
	assign span.span_row    = row_q;
	assign span.span_start  = start_q;
	assign span.span_length = len_q;
	assign span.span_color  = span_color_q;
	assign span.last_span   = last_q;

endmodule

FILE: verif/tb_filled_circle_span_generator_top.sv
// Testbench for filled_circle_span_generator_top: drives circle requests and screen
// register writes, predicts every fill span and checks each one as it leaves the block.
// Depends on fcsg_pkg, the fcsg_if channel interfaces and the block's RTL.
module tb_filled_circle_span_generator_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fcsg_pkg::*;

	localparam int MAX_RAD   = DEF_MAX_RADIUS;
	localparam int COORD_W   = DEF_COORD_BITS;
	localparam int COORD_MAX = (1 << COORD_W) - 1;
	// Idle time after the last span: covers a rejected request still in its check cycles
	localparam int SETTLE_CYCLES = 200;
	// Register indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] cx;
		logic [COORD_W-1:0] cy;
		logic [RAD_W-1:0]   rad;
		logic [COLOR_W-1:0] color;
	} circle_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic [COLOR_W-1:0] color;
		logic               last;
	} span_t;

	logic clk;
	logic arst_n;

	fcsg_cmd_if #(.COORD_BITS(COORD_W)) cmd_if ();
	fcsg_span_if #(.COORD_BITS(COORD_W)) span_if ();
	fcsg_cfg_if cfg_if ();

	filled_circle_span_generator_top #(
		.MAX_RADIUS(MAX_RAD),
		.COORD_BITS(COORD_W)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.span  (span_if),
		.cfg   (cfg_if)
	);

	// Predictor copy of the screen registers and the spans still owed by the block
	logic [SCR_W-1:0] screen_w;
	logic [SCR_W-1:0] screen_h;
	span_t            pending_spans[$];
	int               errors;
	int               send_idle_pct;
	int               recv_stall_pct;

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	task automatic note_error(input string msg);
		errors++;
		if (errors <= 10) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	function automatic void queue_span(input int row, input int start, input int hw,
		input logic [COLOR_W-1:0] color, input logic last);
		span_t s;
		s.row   = COORD_W'(row);
		s.start = COORD_W'(start);
		s.len   = LEN_W'(2 * hw + 1);
		s.color = color;
		s.last  = last;
		pending_spans.push_back(s);
	endfunction

	// Spans of one accepted circle request, in emission order
	function automatic void predict_fill_spans(input circle_t c);
		int cx;
		int cy;
		int rad;
		int hw;
		int r;
		cx  = c.cx;
		cy  = c.cy;
		rad = c.rad;
		if (rad == 0 || rad > MAX_RAD) return;
		if (cx < rad || cx + rad >= int'(screen_w) || cx + rad > COORD_MAX) return;
		if (cy < rad || cy + rad >= int'(screen_h) || cy + rad > COORD_MAX) return;
		queue_span(cy, cx - rad, rad, c.color, rad == 1);
		hw = rad;
		for (r = 1; r < rad; r++) begin
			while (hw > 0 && r * r + hw * hw > rad * rad) hw--;
			queue_span(cy - r, cx - hw, hw, c.color, 1'b0);
			queue_span(cy + r, cx - hw, hw, c.color, r + 1 == rad);
		end
	endfunction

	// Send one circle request; returns at the falling edge after acceptance
	task automatic send_circle(input circle_t c);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_if.valid         <= 1'b1;
		cmd_if.center_x      <= c.cx;
		cmd_if.center_y      <= c.cy;
		cmd_if.circle_radius <= c.rad;
		cmd_if.fill_color    <= c.color;
		do @(posedge clk); while (!cmd_if.ready);
		predict_fill_spans(c);
		@(negedge clk);
	endtask

	task automatic send_xyr(input int cx, input int cy, input int rad,
		input logic [COLOR_W-1:0] color);
		circle_t c;
		c.cx    = COORD_W'(cx);
		c.cy    = COORD_W'(cy);
		c.rad   = RAD_W'(rad);
		c.color = color;
		send_circle(c);
	endtask

	// Stop sending and wait for every owed span
	task automatic wait_spans_done();
		cmd_if.valid <= 1'b0;
		while (pending_spans.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Idle point for register writes: all spans out and the block settled
	task automatic drain();
		wait_spans_done();
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// One register write; only issued while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCR_W-1:0] data);
		cfg_if.valid <= 1'b1;
		cfg_if.addr  <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		if (idx == REG_SCREEN_WIDTH) screen_w = data;
		else if (idx == REG_SCREEN_HEIGHT) screen_h = data;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_screen(input logic [SCR_W-1:0] w, input logic [SCR_W-1:0] h);
		write_reg(REG_SCREEN_WIDTH, w);
		write_reg(REG_SCREEN_HEIGHT, h);
	endtask

	// Mostly circles that fit the current screen, the rest raw field noise
	function automatic circle_t random_circle();
		circle_t c;
		int lim_x;
		int lim_y;
		int maxr;
		int rad;
		lim_x = (int'(screen_w) - 1 < COORD_MAX) ? int'(screen_w) - 1 : COORD_MAX;
		lim_y = (int'(screen_h) - 1 < COORD_MAX) ? int'(screen_h) - 1 : COORD_MAX;
		c.color = $urandom();
		if ($urandom_range(99) < 80 && lim_x >= 2 && lim_y >= 2) begin
			maxr = (lim_x < lim_y ? lim_x : lim_y) / 2;
			if (maxr > MAX_RAD) maxr = MAX_RAD;
			if ($urandom_range(99) < 70) rad = $urandom_range(1, maxr < 8 ? maxr : 8);
			else rad = $urandom_range(1, maxr);
			c.rad = RAD_W'(rad);
			c.cx  = COORD_W'($urandom_range(rad, lim_x - rad));
			c.cy  = COORD_W'($urandom_range(rad, lim_y - rad));
		end else begin
			c.cx  = COORD_W'($urandom_range(COORD_MAX));
			c.cy  = COORD_W'($urandom_range(COORD_MAX));
			c.rad = RAD_W'($urandom_range(63));
		end
		return c;
	endfunction

	// Span sink: random back-pressure, changed on the falling edge
	always @(negedge clk) begin
		span_if.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Span checker
	always @(posedge clk) begin
		span_t want;
		span_t got;
		if (arst_n && span_if.valid && span_if.ready) begin
			got.row   = span_if.span_row;
			got.start = span_if.span_start;
			got.len   = span_if.span_length;
			got.color = span_if.span_color;
			got.last  = span_if.last_span;
			if (pending_spans.size() == 0) begin
				note_error($sformatf("unexpected span row %0d start %0d len %0d color %h last %0b",
					got.row, got.start, got.len, got.color, got.last));
			end else begin
				want = pending_spans.pop_front();
				if (got.row !== want.row || got.start !== want.start ||
					got.len !== want.len || got.color !== want.color ||
					got.last !== want.last) begin
					note_error($sformatf({"span mismatch: expected row %0d start %0d len %0d ",
						"color %h last %0b, got row %0d start %0d len %0d color %h last %0b"},
						want.row, want.start, want.len, want.color, want.last,
						got.row, got.start, got.len, got.color, got.last));
				end
			end
		end
	end

	// Reset screen: radius limits, edge rejection on each side, single-span circle
	task automatic test_reset_screen();
		send_xyr(320, 240, 1, 32'hFFFF_FFFF);
		send_xyr(320, 240, 32, 32'h0000_0000);
		send_xyr(320, 240, 0, 32'h1234_5678);
		send_xyr(320, 240, 33, 32'h1234_5678);
		send_xyr(320, 240, 63, 32'h1234_5678);
		send_xyr(5, 240, 5, 32'hA5A5_A5A5);
		send_xyr(4, 240, 5, 32'hA5A5_A5A5);
		send_xyr(634, 240, 5, 32'h5A5A_5A5A);
		send_xyr(635, 240, 5, 32'h5A5A_5A5A);
		send_xyr(320, 5, 5, 32'hDEAD_BEEF);
		send_xyr(320, 4, 5, 32'hDEAD_BEEF);
		send_xyr(320, 474, 5, 32'hCAFE_F00D);
		send_xyr(320, 475, 5, 32'hCAFE_F00D);
		send_xyr(0, 0, 1, 32'hFFFF_FFFF);
		send_xyr(4095, 4095, 32, 32'hFFFF_FFFF);
		send_xyr(100, 100, 7, 32'h0F0F_F0F0);
		drain();
	endtask

	// Screen register extremes, coordinate overflow and unmapped register indexes
	task automatic test_screen_extremes();
		set_screen(13'd4096, 13'd4096);
		send_xyr(4063, 4063, 32, 32'h8000_0001);
		send_xyr(4064, 2000, 32, 32'h8000_0001);
		drain();
		set_screen(13'd8191, 13'd8191);
		send_xyr(4094, 4094, 1, 32'h7FFF_FFFE);
		send_xyr(4095, 100, 1, 32'h7FFF_FFFE);
		send_xyr(100, 4095, 1, 32'h7FFF_FFFE);
		drain();
		set_screen(13'd0, 13'd480);
		send_xyr(320, 240, 3, 32'h1111_1111);
		drain();
		set_screen(13'd1, 13'd1);
		send_xyr(0, 0, 1, 32'h2222_2222);
		drain();
		set_screen(13'd640, 13'd480);
		write_reg(REG_SPARE_A, 13'd0);
		write_reg(REG_SPARE_B, 13'd0);
		send_xyr(320, 240, 4, 32'h3333_3333);
		drain();
	endtask

	// Random requests under one idle/stall setting on a random screen
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items,
		input bit hold_off);
		logic [SCR_W-1:0] w;
		logic [SCR_W-1:0] h;
		w = SCR_W'($urandom_range(64, 4096));
		h = SCR_W'($urandom_range(64, 4096));
		if ($urandom_range(9) == 0) w = SCR_W'($urandom_range(8191));
		if ($urandom_range(9) == 0) h = SCR_W'($urandom_range(8191));
		set_screen(w, h);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			send_circle(random_circle());
			// sender holds off until the block has emptied
			if (hold_off && i == n_items / 2) wait_spans_done();
		end
		drain();
	endtask

	initial begin
		arst_n               = 1'b0;
		cmd_if.valid         = 1'b0;
		cmd_if.center_x      = '0;
		cmd_if.center_y      = '0;
		cmd_if.circle_radius = '0;
		cmd_if.fill_color    = '0;
		cfg_if.valid         = 1'b0;
		cfg_if.addr          = '0;
		cfg_if.data          = '0;
		span_if.ready        = 1'b0;
		screen_w             = SCREEN_WIDTH_RST;
		screen_h             = SCREEN_HEIGHT_RST;
		errors               = 0;
		send_idle_pct        = 0;
		recv_stall_pct       = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_screen();
		test_screen_extremes();
		test_random_phase(0, 0, 32, 1'b0);
		test_random_phase(85, 0, 32, 1'b1);
		test_random_phase(0, 85, 32, 1'b0);
		test_random_phase(23, 23, 32, 1'b0);

		if (pending_spans.size() != 0) begin
			note_error($sformatf("%0d spans never arrived", pending_spans.size()));
		end
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
